>>> src/lspl_pkg.sv
// shared types and constants for the pyramid level skyline placer
package lspl_pkg;

  localparam int MAX_LEVELS   = 32;
  localparam int MAX_SEGMENTS = 33;
  localparam int DIM_BITS     = 12;
  localparam int SEG_AW       = 6;
  localparam int POS_W        = 14;
  localparam logic [POS_W-1:0] SAT14 = 14'h3FFF;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_GAP   = 2'd1;
  localparam logic [1:0] REG_MIN   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_SEED, ST_SCAN, ST_PICK, ST_FIND, ST_WRT,
    ST_WRC, ST_SHW, ST_SHH, ST_SHD, ST_DIVW, ST_OUT
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] level;
  } seg_t;

  typedef struct packed {
    logic              en;
    logic [SEG_AW-1:0] addr;
    seg_t              data;
  } seg_wr_t;

endpackage

>>> src/lspl_seg_ram.sv
// segment table memory, one write and one registered read per cycle
module lspl_seg_ram (
  input  logic                     clk,
  input  lspl_pkg::seg_wr_t        wr,
  input  logic [lspl_pkg::SEG_AW-1:0] raddr,
  output lspl_pkg::seg_t           rdata_r
);
  import lspl_pkg::*;

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> src/lspl_div.sv
// restoring divider, one quotient bit per cycle
module lspl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [27:0] dividend,
  input  logic [11:0] divisor,
  output logic [27:0] quo,
  output logic        done
);
  import lspl_pkg::*;

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [27:0] quo_r;
  logic [11:0] rem_r;
  logic [11:0] dvs_r;
  logic [12:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_r, quo_r[27]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd27;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? 12'(rem_sh - {1'b0, dvs_r}) : rem_sh[11:0];
      quo_r <= {quo_r[26:0], fits};
    end
  end

  assign quo  = quo_r;
  assign done = !busy_r;

endmodule

>>> src/pyramid_level_skyline_placer_top.sv
// top level: sequencer, segment scan and level placement
//
// channel  dir  beat content
// in_      in   tdata = image_width, image_height
// out_     out  tdata = pos_x .. canvas_height, tlast = last
// cfg_     in   write enable, register index, write data
//
// each level takes two scan passes over the 33 segments plus pick, write,
// multiply, divide wait and output; output can stall until out_tready
// rst_n is synchronous; the segment memory needs no clearing pass
// in_tready is high only while idle; a result holds until out_tready
module pyramid_level_skyline_placer_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // image_width, image_height
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // pos_x, pos_y, level_width, level_height,
                                   // scale_ratio_q16, canvas_width, canvas_height
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import lspl_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0] scale_r;
  logic [7:0]  gap_r;
  logic [11:0] min_r;

  logic [11:0] in_w_r, in_h_r, cur_w_r, cur_h_r, across0_r;
  logic        swapped_r;
  logic [POS_W-1:0] strip_r, extent_r;
  logic [5:0]  n_r;
  logic [27:0] prod_r;
  logic [11:0] mul_a;

  logic [5:0]  cnt_r;
  logic        pe_r;
  logic [5:0]  pidx_r;
  logic        valid_r [MAX_SEGMENTS];

  logic        found_r;
  seg_t        best_r, e0_r, c_r;
  logic [5:0]  best_idx_r, c_idx_r;
  logic [POS_W-1:0] k2_r, nspan_r;
  logic        mfound_r, ifound_r;
  logic [5:0]  midx_r, iidx_r;

  seg_t        rd;
  seg_wr_t     wr;
  logic [5:0]  raddr;

  logic        div_start, div_done;
  logic [27:0] div_quo;

  logic [13:0] pos_x_r, pos_y_r, cw_r, ch_r;
  logic [11:0] ow_r, oh_r;
  logic [16:0] ratio_r;
  logic        last_r;

  logic [11:0] ca, cb, al0;
  logic [12:0] need;
  logic [14:0] strip_sum, k2_sum, lvl_sum, fin_sum;
  logic [POS_W-1:0] newlvl, ext_nxt, fin;
  logic [5:0]  n_nxt;
  logic        last_now, pass_end, better;

  assign ca   = swapped_r ? cur_h_r : cur_w_r;
  assign cb   = swapped_r ? cur_w_r : cur_h_r;
  assign al0  = (in_w_r < in_h_r) ? in_w_r : in_h_r;
  assign need = {1'b0, ca} + {5'd0, gap_r};

  always_comb begin
    case (state_r)
      ST_INIT: mul_a = al0;
      ST_SHW:  mul_a = cur_w_r;
      default: mul_a = cur_h_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= {16'd0, mul_a} * {12'd0, scale_r};
  end

  assign strip_sum = {3'd0, al0} + {2'd0, 13'((prod_r + 28'd65535) >> 16)}
                   + {6'd0, gap_r, 1'b0};
  assign k2_sum  = {1'b0, c_r.start} + {2'd0, need};
  assign lvl_sum = {1'b0, c_r.level} + {3'd0, cb} + {7'd0, gap_r};
  assign newlvl  = lvl_sum > {1'b0, SAT14} ? SAT14 : lvl_sum[13:0];
  assign ext_nxt = newlvl > extent_r ? newlvl : extent_r;
  assign fin_sum = {1'b0, extent_r} + {7'd0, gap_r};
  assign fin     = fin_sum > {1'b0, SAT14} ? SAT14 : fin_sum[13:0];
  assign n_nxt   = n_r + 6'd1;
  assign last_now = (n_nxt >= 6'(MAX_LEVELS)) || (ca <= min_r);
  assign pass_end = pe_r && (pidx_r == 6'(MAX_SEGMENTS - 1));
  assign better  = valid_r[pidx_r] && (rd.span > {1'b0, need}) &&
                   (!found_r || rd.level < best_r.level ||
                    (rd.level == best_r.level && rd.start < best_r.start));

  assign raddr     = cnt_r;
  assign div_start = (state_r == ST_SCAN) && (cnt_r == 6'd0);

  lspl_seg_ram u_ram (.clk(clk), .wr(wr), .raddr(raddr), .rdata_r(rd));

  lspl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend({cb, 16'd0}),
    .divisor(across0_r), .quo(div_quo), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wr        = '0;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_SEED;
      ST_SEED: begin
        wr.en = 1'b1;
        wr.data.start = '0;
        wr.data.span  = strip_sum > {1'b0, SAT14} ? SAT14 : strip_sum[13:0];
        wr.data.level = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: if (pass_end) state_nxt = ST_PICK;
      ST_PICK: state_nxt = ST_FIND;
      ST_FIND: if (pass_end) state_nxt = ST_WRT;
      ST_WRT: begin
        wr.en   = mfound_r || ifound_r;
        wr.addr = mfound_r ? midx_r : iidx_r;
        wr.data = '{start: k2_r, span: nspan_r, level: c_r.level};
        state_nxt = ST_WRC;
      end
      ST_WRC: begin
        wr.en   = 1'b1;
        wr.addr = c_idx_r;
        wr.data = '{start: c_r.start, span: {2'd0, ca}, level: newlvl};
        state_nxt = ST_SHW;
      end
      ST_SHW: state_nxt = ST_SHH;
      ST_SHH: state_nxt = ST_SHD;
      ST_SHD: state_nxt = ST_DIVW;
      ST_DIVW: if (div_done) state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = last_r ? ST_IDLE : ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd32768;
      gap_r   <= 8'd8;
      min_r   <= 12'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale_r <= cfg_wdata;
        REG_GAP:   gap_r   <= cfg_wdata[7:0];
        REG_MIN:   min_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SEGMENTS; i++) valid_r[i] <= 1'b0;
      pe_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      pe_r   <= (state_r == ST_SCAN || state_r == ST_FIND) &&
                (cnt_r < 6'(MAX_SEGMENTS));
      pidx_r <= cnt_r;
      if (state_r == ST_SCAN || state_r == ST_FIND) begin
        if (cnt_r < 6'(MAX_SEGMENTS)) cnt_r <= cnt_r + 6'd1;
      end else begin
        cnt_r <= '0;
      end
      if (state_r == ST_SEED) begin
        for (int i = 1; i < MAX_SEGMENTS; i++) valid_r[i] <= 1'b0;
        valid_r[0] <= 1'b1;
      end else if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        in_w_r <= in_tdata[11:0];
        in_h_r <= in_tdata[23:12];
      end
      ST_SEED: begin
        swapped_r <= !(in_w_r < in_h_r);
        across0_r <= (in_w_r < in_h_r) ? in_h_r : in_w_r;
        strip_r   <= strip_sum > {1'b0, SAT14} ? SAT14 : strip_sum[13:0];
        cur_w_r   <= in_w_r;
        cur_h_r   <= in_h_r;
        extent_r  <= '0;
        n_r       <= '0;
      end
      ST_SCAN: begin
        if (cnt_r == 6'd0) found_r <= 1'b0;
        if (pe_r) begin
          if (pidx_r == 6'd0) e0_r <= rd;
          if (better) begin
            found_r    <= 1'b1;
            best_r     <= rd;
            best_idx_r <= pidx_r;
          end
        end
      end
      ST_PICK: begin
        c_r     <= found_r ? best_r : e0_r;
        c_idx_r <= found_r ? best_idx_r : 6'd0;
      end
      ST_FIND: begin
        if (cnt_r == 6'd0) begin
          k2_r     <= k2_sum > {1'b0, SAT14} ? SAT14 : k2_sum[13:0];
          nspan_r  <= c_r.span > {1'b0, need} ? 14'(c_r.span - {1'b0, need}) : '0;
          mfound_r <= 1'b0;
          ifound_r <= 1'b0;
        end
        if (pe_r) begin
          if (valid_r[pidx_r] && rd.start == k2_r && !mfound_r) begin
            mfound_r <= 1'b1;
            midx_r   <= pidx_r;
          end
          if (!valid_r[pidx_r] && !ifound_r) begin
            ifound_r <= 1'b1;
            iidx_r   <= pidx_r;
          end
        end
      end
      ST_WRC: begin
        extent_r <= ext_nxt;
        pos_x_r  <= swapped_r ? c_r.level : c_r.start;
        pos_y_r  <= swapped_r ? c_r.start : c_r.level;
        ow_r     <= cur_w_r;
        oh_r     <= cur_h_r;
        cw_r     <= swapped_r ? ext_nxt : strip_r;
        ch_r     <= swapped_r ? strip_r : ext_nxt;
      end
      ST_SHH: cur_w_r <= prod_r[27:16];
      ST_SHD: cur_h_r <= prod_r[27:16];
      ST_DIVW: begin
        if (div_done) begin
          n_r     <= n_nxt;
          last_r  <= last_now;
          ratio_r <= (across0_r == 12'd0) ? 17'd0 : div_quo[16:0];
          if (last_now) begin
            if (swapped_r) cw_r <= fin;
            else ch_r <= fin;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tlast  = last_r;
  assign out_tdata  = {7'd0, ch_r, cw_r, ratio_r, oh_r, ow_r, pos_y_r, pos_x_r};

endmodule

>>> bench/placer_checker.sv
// checker: watches the placer channels, predicts level placements and compares them
`timescale 1ns / 100ps
module placer_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [23:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           pending_levels,
  output int           levels_seen
);
  import lspl_pkg::*;

  typedef struct packed {
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic [11:0] lw;
    logic [11:0] lh;
    logic [16:0] ratio;
    logic [13:0] cw;
    logic [13:0] ch;
    logic        last;
  } level_t;

  level_t expected_levels[$];
  logic [15:0] scale_q;
  logic [7:0]  gap_px;
  logic [11:0] min_px;

  function automatic int unsigned sat(int unsigned v);
    return v > 16383 ? 16383 : v;
  endfunction

  task automatic place_image(input logic [11:0] w, input logic [11:0] h);
    int unsigned sstart[MAX_SEGMENTS], sspan[MAX_SEGMENTS], slevel[MAX_SEGMENTS];
    bit          svalid[MAX_SEGMENTS];
    bit          swap, found;
    int unsigned along0, across0, strip, cw, ch, ext, ca, cb, need, ps, pl, k2, nspan;
    int          n, c, t;
    level_t      r;
    level_t      lv[$];
    longint unsigned q;
    swap = !(w < h);
    along0 = swap ? h : w;
    across0 = swap ? w : h;
    strip = sat(along0 + ((along0 * scale_q + 65535) >> 16) + 2 * gap_px);
    foreach (svalid[i]) begin
      svalid[i] = 0;
      sstart[i] = 0;
      sspan[i] = 0;
      slevel[i] = 0;
    end
    sspan[0] = strip;
    svalid[0] = 1;
    cw = w;
    ch = h;
    ext = 0;
    n = 0;
    forever begin
      ca = swap ? ch : cw;
      cb = swap ? cw : ch;
      need = ca + gap_px;
      c = 0;
      t = -1;
      found = 0;
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        if (!svalid[i] || sspan[i] <= need) continue;
        if (!found || slevel[i] < slevel[c] ||
            (slevel[i] == slevel[c] && sstart[i] < sstart[c])) begin
          c = i;
          found = 1;
        end
      end
      ps = sstart[c];
      pl = slevel[c];
      k2 = sat(ps + need);
      nspan = sspan[c] > need ? sspan[c] - need : 0;
      for (int i = 0; i < MAX_SEGMENTS; i++)
        if (t < 0 && svalid[i] && sstart[i] == k2) t = i;
      for (int i = 0; i < MAX_SEGMENTS; i++)
        if (t < 0 && !svalid[i]) t = i;
      if (t >= 0) begin
        sstart[t] = k2;
        sspan[t] = nspan;
        slevel[t] = pl;
        svalid[t] = 1;
      end
      sspan[c] = ca;
      slevel[c] = sat(pl + cb + gap_px);
      if (slevel[c] > ext) ext = slevel[c];
      r.pos_x = 14'(swap ? pl : ps);
      r.pos_y = 14'(swap ? ps : pl);
      r.lw = 12'(cw);
      r.lh = 12'(ch);
      q = across0 != 0 ? ((longint'(cb) << 16) / across0) : 0;
      r.ratio = q[16:0];
      r.cw = 14'(swap ? ext : strip);
      r.ch = 14'(swap ? strip : ext);
      r.last = 0;
      lv = {lv, r};
      n++;
      cw = ((cw * scale_q) >> 16) & 12'hFFF;
      ch = ((ch * scale_q) >> 16) & 12'hFFF;
      ca = swap ? ch : cw;
      if (n >= MAX_LEVELS || ca <= min_px) break;
    end
    if (swap) lv[n-1].cw = 14'(sat(ext + gap_px));
    else lv[n-1].ch = 14'(sat(ext + gap_px));
    lv[n-1].last = 1;
    foreach (lv[i]) expected_levels = {expected_levels, lv[i]};
  endtask

  task automatic cmp(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $error("%s expected %0d actual %0d", name, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    level_t e;
    if (!rst_n) begin
      scale_q <= 16'd32768;
      gap_px <= 8'd8;
      min_px <= 12'd12;
      fail_count = 0;
      levels_seen = 0;
      expected_levels.delete();
      pending_levels = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE: scale_q <= cfg_wdata;
          REG_GAP:   gap_px <= cfg_wdata[7:0];
          REG_MIN:   min_px <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) place_image(in_tdata[11:0], in_tdata[23:12]);
      if (out_tvalid && out_tready) begin
        levels_seen++;
        if (expected_levels.size() == 0) begin
          $error("level beat with no expectation");
          fail_count++;
        end else begin
          e = expected_levels.pop_front();
          cmp("pos_x", e.pos_x, out_tdata[13:0]);
          cmp("pos_y", e.pos_y, out_tdata[27:14]);
          cmp("level_width", e.lw, out_tdata[39:28]);
          cmp("level_height", e.lh, out_tdata[51:40]);
          cmp("scale_ratio_q16", e.ratio, out_tdata[68:52]);
          cmp("canvas_width", e.cw, out_tdata[82:69]);
          cmp("canvas_height", e.ch, out_tdata[96:83]);
          cmp("last", e.last, out_tlast);
        end
      end
      pending_levels = expected_levels.size();
    end
  end
endmodule

>>> bench/testbench.sv
// testbench top: drives images and register writes into the placer and gives the verdict
`timescale 1ns / 100ps
module testbench;
  import lspl_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [23:0]  in_tdata = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = REG_SCALE;
  logic [15:0]  cfg_wdata = 0;
  int           fail_count, pending_levels, levels_seen;
  int           images_sent = 0;
  bit           sink_on = 0;
  int           sink_wait = 0;

  always #6 clk = ~clk;

  pyramid_level_skyline_placer_top dut (.*);
  placer_checker chk (.*);

  task automatic send_image(input logic [11:0] w, input logic [11:0] h);
    repeat ($urandom_range(0, 10)) @(posedge clk);
    in_tvalid <= 1;
    in_tdata <= {h, w};
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 0;
    images_sent++;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending_levels != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] s, input logic [7:0] g, input logic [11:0] m);
    drain();
    write_reg(REG_SCALE, s);
    write_reg(REG_GAP, {8'd0, g});
    write_reg(REG_MIN, {4'd0, m});
  endtask

  task automatic random_image;
    logic [11:0] w, h;
    case ($urandom_range(0, 3))
      0: begin w = 12'($urandom_range(1, 4095)); h = 12'($urandom_range(1, 4095)); end
      1: begin w = 12'($urandom_range(1, 64)); h = 12'($urandom_range(1, 64)); end
      2: begin w = 12'($urandom_range(1, 400)); h = 12'($urandom_range(1, 4095)); end
      default: begin w = 12'($urandom_range(1, 4095)); h = 12'($urandom_range(1, 400)); end
    endcase
    send_image(w, h);
  endtask

  // result sink: holds out_tready low for a random wait before each beat
  always @(posedge clk) begin
    if (!sink_on || (out_tvalid && out_tready)) begin
      out_tready <= 0;
      sink_wait <= $urandom_range(0, 10);
    end else if (out_tvalid && !out_tready) begin
      if (sink_wait == 0) out_tready <= 1;
      else sink_wait <= sink_wait - 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    sink_on <= 1;
    @(posedge clk);
    send_image(12'd1, 12'd1);
    send_image(12'd4095, 12'd4095);
    send_image(12'd4095, 12'd1);
    send_image(12'd1, 12'd4095);
    send_image(12'd640, 12'd480);
    send_image(12'd480, 12'd640);
    send_image(12'd2730, 12'd1365);
    send_image(12'd100, 12'd101);
    set_all(16'd65535, 8'd255, 12'd0);
    send_image(12'd4095, 12'd4095);
    send_image(12'd3000, 12'd200);
    send_image(12'd7, 12'd9);
    set_all(16'd1, 8'd0, 12'd4095);
    send_image(12'd4095, 12'd2048);
    send_image(12'd1, 12'd2);
    set_all(16'd60000, 8'd0, 12'd0);
    send_image(12'd2048, 12'd4095);
    send_image(12'd30, 12'd20);
    set_all(16'd50000, 8'd3, 12'd1);
    send_image(12'd1024, 12'd1024);
    send_image(12'd2, 12'd4000);
    for (int p = 0; p < 6; p++) begin
      set_all(16'($urandom_range(1, 52000)), 8'($urandom_range(0, 255)),
              12'($urandom_range(0, 200)));
      repeat (40) random_image();
    end
    set_all(16'd32768, 8'd8, 12'd12);
    repeat (10) random_image();
    drain();
    $display("images sent: %0d, levels checked: %0d", images_sent, levels_seen);
    $display("covered axis swap, saturation, full segment tables and register extremes");
    if (fail_count == 0 && pending_levels == 0) begin
      $display("PASS pyramid_level_skyline_placer_top");
    end else begin
      $display("FAIL pyramid_level_skyline_placer_top");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("FAIL pyramid_level_skyline_placer_top");
    $finish;
  end
endmodule
